>>> hw/rtl/mvm_pkg.sv
// Shared definitions for the matrix-vector multiplier: field widths, operation
// codes, configuration register indexes and parameter defaults.
// Depends on nothing; imported by matrix_vector_multiply, not by mvm_vec_mem.
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

	// Parameter defaults handed to the top level.
	localparam int unsigned MaxColsDefault   = 1024;
	localparam int unsigned DataWidthDefault = 32;

	// Fixed widths of the interface fields.
	localparam int unsigned ValueWidth   = 32;
	localparam int unsigned NumColsWidth = 11;
	localparam int unsigned RowWidth     = 16;
	localparam int unsigned CfgDataWidth = 16;

	// Width that holds any clamped column count (at most 2047, as num_cols is 11 bits).
	localparam int unsigned ColCountWidth = 17;

	// Operation carried by each input beat.
	typedef enum logic {
		OP_LOAD_VECTOR = 1'b0,
		OP_MATRIX_ELEM = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_NUM_COLS = 1'b0,
		CFG_NUM_ROWS = 1'b1
	} cfg_index_t;

endpackage : mvm_pkg

`default_nettype wire

>>> hw/rtl/mvm_vec_mem.sv
// Vector store of the matrix-vector multiplier: one write port and one read
// port, read data registered. Uses nothing from mvm_pkg and is sized
// entirely by its parameters.
`timescale 1ns / 1ps
`default_nettype none

module mvm_vec_mem #(
	parameter int unsigned Depth = 1024,
	parameter int unsigned Width = 32,
	parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AddrWidth-1:0] wr_addr,
	input  wire logic [Width-1:0]     wr_data,
	input  wire logic                 rd_en,
	input  wire logic [AddrWidth-1:0] rd_addr,
	output      logic [Width-1:0]     rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data only moves on a read, so a stalled consumer keeps it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : mvm_vec_mem

`default_nettype wire

>>> hw/rtl/matrix_vector_multiply.sv
// Top level of the matrix-vector multiplier y = A*x: input handling, row and
// column bookkeeping, multiply-accumulate pipeline and result register.
// Depends on mvm_pkg and mvm_vec_mem.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                    | Direction | Beat carries
// ----------+------------------------------------------+-----------+----------------------------
// item      | item_valid, item_stall, operation, value | in        | vector load or matrix element
// result    | result_valid, result_stall, row_index,   | out       | one finished row
//           | row_sum, last_row                        |           |
// config    | cfg_we, cfg_index, cfg_data              | in        | register write, no handshake
//
// One item is taken per clock cycle in steady state while item_stall is low; a row's
// last element passes stage 1 and stage 2 before its sum enters the result register.
// The single read port of the vector store and the one multiplier set this rate.
// Reset clears the positions, the accumulator, all pipeline valid bits and sets
// num_cols and num_rows to one; the vector store is not cleared.
// A stalled result only holds up the input once it blocks a row-ending element
// at the accumulate stage and the stages behind it are full.

module matrix_vector_multiply #(
	parameter int unsigned MAX_COLS   = mvm_pkg::MaxColsDefault,
	parameter int unsigned DATA_WIDTH = mvm_pkg::DataWidthDefault
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input items
	input  wire logic                                  item_valid,
	output      logic                                  item_stall,
	input  wire mvm_pkg::op_t                          operation,
	input  wire logic signed [mvm_pkg::ValueWidth-1:0] value,
	// Results
	output      logic                                  result_valid,
	input  wire logic                                  result_stall,
	output      logic [mvm_pkg::RowWidth-1:0]          row_index,
	output      logic signed [DATA_WIDTH-1:0]          row_sum,
	output      logic                                  last_row,
	// Configuration
	input  wire logic                                  cfg_we,
	input  wire mvm_pkg::cfg_index_t                   cfg_index,
	input  wire logic [mvm_pkg::CfgDataWidth-1:0]      cfg_data
);

	import mvm_pkg::*;

	localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [NumColsWidth-1:0] num_cols_q;
	logic [RowWidth-1:0]     num_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= NumColsWidth'(1);
			num_rows_q <= RowWidth'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_COLS: num_cols_q <= cfg_data[NumColsWidth-1:0];
				CFG_NUM_ROWS: num_rows_q <= cfg_data[RowWidth-1:0];
				default:      num_cols_q <= num_cols_q;
			endcase
		end
	end

	// Last column and last row in use. A zero count acts as one, and the
	// column count is held to the size of the vector store.
	logic [ColCountWidth-1:0] cols_in_use;
	logic [AW-1:0]            last_col;
	logic [RowWidth-1:0]      last_row_idx;

	always_comb begin
		if (num_cols_q == '0) begin
			cols_in_use = ColCountWidth'(1);
		end else if (ColCountWidth'(num_cols_q) > ColCountWidth'(MAX_COLS)) begin
			cols_in_use = ColCountWidth'(MAX_COLS);
		end else begin
			cols_in_use = ColCountWidth'(num_cols_q);
		end
		last_col     = AW'(cols_in_use - ColCountWidth'(1));
		last_row_idx = (num_rows_q == '0) ? '0 : num_rows_q - RowWidth'(1);
	end

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	// Stage 1 holds a matrix element together with its vector entry read from
	// the store; stage 2 holds the product; the result register follows.
	logic                  valid_s1, valid_s2;
	logic                  result_valid_q;
	logic                  row_end_s1, row_end_s2;
	logic                  out_free, s2_go, s2_can_load, s1_go, s1_can_load;
	logic                  item_accept, load_accept, elem_accept;

	assign out_free    = !result_valid_q || !result_stall;
	assign s2_go       = valid_s2 && (!row_end_s2 || out_free);
	assign s2_can_load = !valid_s2 || s2_go;
	assign s1_go       = valid_s1 && s2_can_load;
	assign s1_can_load = !valid_s1 || s1_go;

	assign item_stall  = !s1_can_load;
	assign item_accept = item_valid && s1_can_load;
	assign load_accept = item_accept && (operation == OP_LOAD_VECTOR);
	assign elem_accept = item_accept && (operation == OP_MATRIX_ELEM);

	// ------------------------------------------------------------------
	// Positions and vector store access
	// ------------------------------------------------------------------
	logic [AW-1:0]       load_pos_q, col_pos_q;
	logic [RowWidth-1:0] row_pos_q;
	logic [AW-1:0]       load_eff, col_eff;
	logic                load_wrap, row_end, matrix_end;
	logic [DATA_WIDTH-1:0] value_ext;
	logic [DATA_WIDTH-1:0] vec_rd_data;

	// A position left beyond the last column by a smaller num_cols is
	// treated as the last column, which also ends the row early.
	assign load_eff   = (load_pos_q > last_col) ? last_col : load_pos_q;
	assign col_eff    = (col_pos_q > last_col) ? last_col : col_pos_q;
	assign load_wrap  = (load_eff == last_col);
	assign row_end    = (col_eff == last_col);
	assign matrix_end = (row_pos_q >= last_row_idx);
	assign value_ext  = DATA_WIDTH'(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_pos_q  <= '0;
			row_pos_q  <= '0;
		end else begin
			if (load_accept) begin
				load_pos_q <= load_wrap ? '0 : load_eff + AW'(1);
			end
			if (elem_accept) begin
				if (row_end) begin
					col_pos_q <= '0;
					row_pos_q <= matrix_end ? '0 : row_pos_q + RowWidth'(1);
				end else begin
					col_pos_q <= col_eff + AW'(1);
				end
			end
		end
	end

	// A load always completes its write before any later element issues its
	// read, so the store needs no forwarding path.
	mvm_vec_mem #(
		.Depth    (MAX_COLS),
		.Width    (DATA_WIDTH),
		.AddrWidth(AW)
	) u_vec_mem (
		.clk    (clk),
		.wr_en  (load_accept),
		.wr_addr(load_eff),
		.wr_data(value_ext),
		.rd_en  (elem_accept),
		.rd_addr(col_eff),
		.rd_data(vec_rd_data)
	);

	// ------------------------------------------------------------------
	// Stage 1: element waits for its vector entry
	// ------------------------------------------------------------------
	logic [DATA_WIDTH-1:0] value_s1;
	logic [RowWidth-1:0]   row_s1, row_s2;
	logic                  mat_end_s1, mat_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_can_load) begin
			valid_s1 <= elem_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_accept) begin
			value_s1   <= value_ext;
			row_s1     <= row_pos_q;
			row_end_s1 <= row_end;
			mat_end_s1 <= matrix_end;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: product, wrapped to the data width
	// ------------------------------------------------------------------
	logic [DATA_WIDTH-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_can_load) begin
			valid_s2 <= s1_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			prod_s2    <= DATA_WIDTH'(value_s1 * vec_rd_data);
			row_s2     <= row_s1;
			row_end_s2 <= row_end_s1;
			mat_end_s2 <= mat_end_s1;
		end
	end

	// ------------------------------------------------------------------
	// Accumulate and result register
	// ------------------------------------------------------------------
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] acc_sum;
	logic [RowWidth-1:0]   row_index_q;
	logic [DATA_WIDTH-1:0] row_sum_q;
	logic                  last_row_q;

	assign acc_sum = acc_q + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (s2_go) begin
				acc_q <= row_end_s2 ? '0 : acc_sum;
			end
			if (s2_go && row_end_s2) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && row_end_s2) begin
			row_index_q <= row_s2;
			row_sum_q   <= acc_sum;
			last_row_q  <= mat_end_s2;
		end
	end

	assign result_valid = result_valid_q;
	assign row_index    = row_index_q;
	assign row_sum      = row_sum_q;
	assign last_row     = last_row_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A row-ending product blocked by a full result register must wait there.
	a_row_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && row_end_s2 && !out_free |=> valid_s2 && row_end_s2)
		else $error("row-ending product left stage 2 while the result was blocked");

	// An accepted element never overwrites a stage-1 entry that did not move on.
	a_no_s1_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		elem_accept |-> !valid_s1 || s1_go)
		else $error("stage 1 overrun");

	// The accumulator starts from zero after every finished row.
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && row_end_s2 |=> acc_q == '0)
		else $error("accumulator not cleared at row end");

	// After the final row of a matrix the row position returns to zero.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		elem_accept && row_end && matrix_end |=> row_pos_q == '0)
		else $error("row position did not wrap after the final row");

	// A result is loaded only when the register is free to take it.
	a_result_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && row_end_s2 |-> out_free)
		else $error("result register overwritten while stalled");

endmodule : matrix_vector_multiply

`default_nettype wire
